/* src/sorted_token_set_assert.svh */
// Assertion macros shared by the sorted token set modules.
// Both macros expect clk_i and rst_ni to be visible at the point of use.
`ifndef SORTED_TOKEN_SET_ASSERT_SVH
`define SORTED_TOKEN_SET_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define STSET_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define STSET_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/stset_pkg.sv */
package stset_pkg;

  typedef enum logic [1:0] {
    MODE_BYTE,
    MODE_CP,
    MODE_BLOCK,
    MODE_READ
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_UNICODE,
    ST_FULL,
    ST_TOO_LONG,
    ST_RANGE
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_KEYP,
    S_ENC,
    S_SI,
    S_SRCH,
    S_ORD,
    S_CRD,
    S_CCHK,
    S_SHIFT,
    S_SHWR,
    S_CPRD,
    S_CPWR,
    S_DONE,
    S_EMIT,
    S_RDORD,
    S_RDLEN,
    S_RDCHK,
    S_RDB,
    S_RDEMIT
  } state_e;

  localparam logic [31:0] CP_1B_MAX = 32'h0000_007F;
  localparam logic [31:0] CP_2B_MAX = 32'h0000_07FF;
  localparam logic [31:0] CP_3B_MAX = 32'h0000_FFFF;
  localparam logic [31:0] CP_MAX    = 32'h0010_FFFF;
  localparam logic [7:0]  LEAD_2B   = 8'hC0;
  localparam logic [7:0]  LEAD_3B   = 8'hE0;
  localparam logic [7:0]  LEAD_4B   = 8'hF0;
  localparam logic [7:0]  CONT_BYTE = 8'h80;
  localparam logic [7:0]  CONT_MASK = 8'h3F;

  localparam logic [31:0] BLK_LATIN_FIRST = 32'h0000_0000;
  localparam logic [31:0] BLK_LATIN_LAST  = 32'h0000_007F;
  localparam logic [31:0] BLK_PUNCT_FIRST = 32'h0000_2000;
  localparam logic [31:0] BLK_PUNCT_LAST  = 32'h0000_206F;

  typedef struct packed {
    logic [2:0]      len;   // zero marks a codepoint beyond the Unicode range
    logic [3:0][7:0] b;     // b[0] is the leading byte
  } utf8_t;

  typedef struct packed {
    logic    take;
    logic    key_pend;
    logic    key_enc;
    logic    srch_init;
    logic    mid_rd;
    logic    len_rd;
    logic    byte_rd;
    logic    i_inc;
    logic    go_lo;
    logic    go_hi;
    logic    sh_init;
    logic    sh_rd;
    logic    sh_wr;
    logic    place;
    logic    cp_wr;
    logic    cnt_inc;
    logic    cp_inc;
    logic    rd_ord;
    logic    st_set;
    status_e st_val;
    logic    emit;
    logic    emit_byte;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  last;
    logic  ovf;
    logic  enc_bad;
    logic  lo_lt_hi;
    logic  cnt_full;
    logic  i_eq_m;
    logic  elen_eq_klen;
    logic  elen_lt_klen;
    logic  byte_eq;
    logic  byte_lt;
    logic  p_gt_lo;
    logic  i_eq_klen;
    logic  cp_final;
    logic  idx_oob;
    logic  elen_zero;
    logic  rd_last;
    logic  out_free;
  } dp_sts_t;

  function automatic utf8_t utf8_encode(input logic [31:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= CP_1B_MAX) begin
      r.len  = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp <= CP_2B_MAX) begin
      r.len  = 3'd2;
      r.b[0] = {3'b000, cp[10:6]} | LEAD_2B;
      r.b[1] = ({2'b00, cp[5:0]} & CONT_MASK) | CONT_BYTE;
    end else if (cp <= CP_3B_MAX) begin
      r.len  = 3'd3;
      r.b[0] = {4'b0000, cp[15:12]} | LEAD_3B;
      r.b[1] = {2'b00, cp[11:6]} | CONT_BYTE;
      r.b[2] = {2'b00, cp[5:0]} | CONT_BYTE;
    end else if (cp <= CP_MAX) begin
      r.len  = 3'd4;
      r.b[0] = {5'b00000, cp[20:18]} | LEAD_4B;
      r.b[1] = {2'b00, cp[17:12]} | CONT_BYTE;
      r.b[2] = {2'b00, cp[11:6]} | CONT_BYTE;
      r.b[3] = {2'b00, cp[5:0]} | CONT_BYTE;
    end
    return r;
  endfunction

endpackage

/* src/stset_in_if.sv */
interface stset_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        last;
  logic [31:0] codepoint;
  logic        block_select;
  logic [7:0]  entry_index;

  modport source (
    output valid, mode, data_byte, has_byte, last, codepoint, block_select, entry_index,
    input  ready
  );
  modport sink (
    input  valid, mode, data_byte, has_byte, last, codepoint, block_select, entry_index,
    output ready
  );
endinterface

/* src/stset_out_if.sv */
interface stset_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [8:0] entry_count;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [5:0] out_length;
  logic       last_result;

  modport source (
    output valid, status, entry_count, out_byte, out_valid, out_length, last_result,
    input  ready
  );
  modport sink (
    input  valid, status, entry_count, out_byte, out_valid, out_length, last_result,
    output ready
  );
endinterface

/* src/stset_ctrl.sv */
module stset_ctrl import stset_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        // No item is taken while the block is held in reset.
        in_ready_o = rst_ni;
        if (in_valid_i && rst_ni) begin
          cmd_o.take = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.mode)
          MODE_BYTE: begin
            if (!sts_i.last) begin
              state_d = S_IDLE;
            end else if (sts_i.ovf) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = ST_TOO_LONG;
              state_d      = S_EMIT;
            end else begin
              state_d = S_KEYP;
            end
          end
          MODE_CP, MODE_BLOCK: state_d = S_ENC;
          MODE_READ: begin
            if (sts_i.idx_oob) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = ST_RANGE;
              state_d      = S_EMIT;
            end else begin
              state_d = S_RDORD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_KEYP: begin
        cmd_o.key_pend = 1'b1;
        state_d        = S_SI;
      end
      S_ENC: begin
        if (sts_i.enc_bad) begin
          cmd_o.st_set = 1'b1;
          cmd_o.st_val = ST_BAD_UNICODE;
          state_d      = S_EMIT;
        end else begin
          cmd_o.key_enc = 1'b1;
          state_d       = S_SI;
        end
      end
      S_SI: begin
        cmd_o.srch_init = 1'b1;
        state_d         = S_SRCH;
      end
      S_SRCH: begin
        if (sts_i.lo_lt_hi) begin
          cmd_o.mid_rd = 1'b1;
          state_d      = S_ORD;
        end else if (sts_i.cnt_full) begin
          cmd_o.st_set = 1'b1;
          cmd_o.st_val = ST_FULL;
          state_d      = S_EMIT;
        end else begin
          cmd_o.sh_init = 1'b1;
          state_d       = S_SHIFT;
        end
      end
      S_ORD: begin
        cmd_o.len_rd = 1'b1;
        state_d      = S_CRD;
      end
      S_CRD: begin
        // All common bytes matched: the shorter token sorts first.
        if (sts_i.i_eq_m) begin
          if (sts_i.elen_eq_klen) begin
            state_d = S_DONE;
          end else begin
            cmd_o.go_lo = sts_i.elen_lt_klen;
            cmd_o.go_hi = !sts_i.elen_lt_klen;
            state_d     = S_SRCH;
          end
        end else begin
          cmd_o.byte_rd = 1'b1;
          state_d       = S_CCHK;
        end
      end
      S_CCHK: begin
        if (sts_i.byte_eq) begin
          cmd_o.i_inc = 1'b1;
          state_d     = S_CRD;
        end else begin
          cmd_o.go_lo = sts_i.byte_lt;
          cmd_o.go_hi = !sts_i.byte_lt;
          state_d     = S_SRCH;
        end
      end
      S_SHIFT: begin
        if (sts_i.p_gt_lo) begin
          cmd_o.sh_rd = 1'b1;
          state_d     = S_SHWR;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_CPRD;
        end
      end
      S_SHWR: begin
        cmd_o.sh_wr = 1'b1;
        state_d     = S_SHIFT;
      end
      S_CPRD: begin
        if (sts_i.i_eq_klen) begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.byte_rd = 1'b1;
          state_d       = S_CPWR;
        end
      end
      S_CPWR: begin
        cmd_o.cp_wr = 1'b1;
        state_d     = S_CPRD;
      end
      S_DONE: begin
        cmd_o.st_set = 1'b1;
        cmd_o.st_val = ST_OK;
        if (sts_i.mode == MODE_BLOCK && !sts_i.cp_final) begin
          cmd_o.cp_inc = 1'b1;
          state_d      = S_ENC;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_RDORD: begin
        cmd_o.rd_ord = 1'b1;
        state_d      = S_RDLEN;
      end
      S_RDLEN: begin
        cmd_o.len_rd = 1'b1;
        state_d      = S_RDCHK;
      end
      S_RDCHK: begin
        if (sts_i.elen_zero) begin
          cmd_o.st_set = 1'b1;
          cmd_o.st_val = ST_OK;
          state_d      = S_EMIT;
        end else begin
          state_d = S_RDB;
        end
      end
      S_RDB: begin
        cmd_o.byte_rd = 1'b1;
        state_d       = S_RDEMIT;
      end
      S_RDEMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_byte = 1'b1;
          cmd_o.i_inc     = 1'b1;
          state_d         = sts_i.rd_last ? S_IDLE : S_RDB;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* src/stset_dp.sv */
module stset_dp import stset_pkg::*; #(
  parameter int unsigned MAX_ENTRIES   = 256,
  parameter int unsigned MAX_TOKEN_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  input  logic [31:0] codepoint_i,
  input  logic        block_select_i,
  input  logic [7:0]  entry_index_i,
  input  logic        res_ready_i,
  output logic        res_valid_o,
  output logic [2:0]  status_o,
  output logic [8:0]  entry_count_o,
  output logic [7:0]  out_byte_o,
  output logic        out_valid_o,
  output logic [5:0]  out_length_o,
  output logic        last_result_o
);

  localparam int unsigned SLOT_W      = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ROW_W       = $clog2(MAX_TOKEN_LEN);
  localparam int unsigned LEN_W       = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned BYTES_DEPTH = MAX_ENTRIES * (2 ** ROW_W);
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_ENTRIES);
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_TOKEN_LEN);

  // Token bytes live in a fixed row per slot; the sort order is kept in a
  // separate table of slot numbers, so an insert only shifts that table.
  logic [7:0]        bytes_mem [BYTES_DEPTH];
  logic [LEN_W-1:0]  len_mem   [MAX_ENTRIES];
  logic [SLOT_W-1:0] ord_mem   [MAX_ENTRIES];
  logic [7:0]        pend_mem  [MAX_TOKEN_LEN];

  logic [CNT_W-1:0]  cnt_q, lo_q, hi_q;
  logic [LEN_W-1:0]  plen_q;
  logic              povf_q, res_vld_q;

  mode_e             mode_q;
  logic              last_q, blk_q, src_pend_q;
  logic [7:0]        idx_q;
  logic [31:0]       cp_q;
  utf8_t             enc_q;
  logic [LEN_W-1:0]  klen_q, i_q, len_rd_q;
  logic [CNT_W-1:0]  mid_q, p_q;
  logic [SLOT_W-1:0] slot_q, ord_rd_q;
  logic [7:0]        bytes_rd_q, pend_rd_q, enc_rd_q;
  status_e           st_q;
  logic [2:0]        res_st_q;
  logic [8:0]        res_cnt_q;
  logic [7:0]        res_byte_q;
  logic              res_bvld_q, res_last_q;
  logic [5:0]        res_len_q;

  utf8_t             enc_c;
  logic [CNT_W-1:0]  mid_c, pm1_c;
  logic [LEN_W-1:0]  m_c;
  logic [7:0]        kbyte_c;
  logic [SLOT_W-1:0] ord_raddr_c;
  logic              out_free_c, pend_clr_c, rd_last_c;

  assign enc_c       = utf8_encode(cp_q);
  assign mid_c       = lo_q + ((hi_q - lo_q) >> 1);
  assign pm1_c       = p_q - 1'b1;
  assign m_c         = (len_rd_q < klen_q) ? len_rd_q : klen_q;
  assign kbyte_c     = src_pend_q ? pend_rd_q : enc_rd_q;
  assign out_free_c  = !res_vld_q || res_ready_i;
  assign pend_clr_c  = cmd_i.emit && !cmd_i.emit_byte && (mode_q == MODE_BYTE);
  assign rd_last_c   = (LEN_W'(i_q + 1'b1) == len_rd_q);

  always_comb begin
    priority if (cmd_i.rd_ord) begin
      ord_raddr_c = SLOT_W'(idx_q);
    end else if (cmd_i.sh_rd) begin
      ord_raddr_c = SLOT_W'(pm1_c);
    end else begin
      ord_raddr_c = SLOT_W'(mid_c);
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      plen_q    <= '0;
      povf_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.srch_init) begin
        lo_q <= '0;
        hi_q <= cnt_q;
      end else if (cmd_i.go_lo) begin
        lo_q <= mid_q + 1'b1;
      end else if (cmd_i.go_hi) begin
        hi_q <= mid_q;
      end
      if (pend_clr_c) begin
        plen_q <= '0;
        povf_q <= 1'b0;
      end else if (cmd_i.take && mode_e'(mode_i) == MODE_BYTE && has_byte_i) begin
        if (plen_q < MaxLen) begin
          plen_q <= plen_q + 1'b1;
        end else begin
          povf_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        res_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mode_q <= mode_e'(mode_i);
      last_q <= last_i;
      blk_q  <= block_select_i;
      idx_q  <= entry_index_i;
      if (mode_e'(mode_i) == MODE_CP) begin
        cp_q <= codepoint_i;
      end else begin
        cp_q <= block_select_i ? BLK_PUNCT_FIRST : BLK_LATIN_FIRST;
      end
    end else if (cmd_i.cp_inc) begin
      cp_q <= cp_q + 1'b1;
    end
    if (cmd_i.key_enc) begin
      enc_q      <= enc_c;
      klen_q     <= LEN_W'(enc_c.len);
      src_pend_q <= 1'b0;
    end else if (cmd_i.key_pend) begin
      klen_q     <= plen_q;
      src_pend_q <= 1'b1;
    end
    if (cmd_i.mid_rd) begin
      mid_q <= mid_c;
    end
    if (cmd_i.sh_init) begin
      p_q <= cnt_q;
    end else if (cmd_i.sh_wr) begin
      p_q <= pm1_c;
    end
    if (cmd_i.len_rd || cmd_i.place) begin
      i_q <= '0;
    end else if (cmd_i.i_inc || cmd_i.cp_wr) begin
      i_q <= i_q + 1'b1;
    end
    if (cmd_i.len_rd) begin
      slot_q <= ord_rd_q;
    end
    if (cmd_i.st_set) begin
      st_q <= cmd_i.st_val;
    end
    // The count is captured with the result so that a following item cannot
    // change it while the result waits.
    if (cmd_i.emit) begin
      res_st_q   <= cmd_i.emit_byte ? ST_OK : st_q;
      res_cnt_q  <= 9'(cnt_q);
      res_byte_q <= cmd_i.emit_byte ? bytes_rd_q : 8'h00;
      res_bvld_q <= cmd_i.emit_byte;
      res_len_q  <= cmd_i.emit_byte ? 6'(len_rd_q) : 6'd0;
      res_last_q <= cmd_i.emit_byte ? rd_last_c : 1'b1;
    end
  end

  // Memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && mode_e'(mode_i) == MODE_BYTE && has_byte_i && plen_q < MaxLen) begin
      pend_mem[plen_q[ROW_W-1:0]] <= data_byte_i;
    end
    if (cmd_i.byte_rd) begin
      pend_rd_q  <= pend_mem[i_q[ROW_W-1:0]];
      enc_rd_q   <= enc_q.b[i_q[1:0]];
      bytes_rd_q <= bytes_mem[{slot_q, i_q[ROW_W-1:0]}];
    end
    if (cmd_i.cp_wr) begin
      bytes_mem[{cnt_q[SLOT_W-1:0], i_q[ROW_W-1:0]}] <= kbyte_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mid_rd || cmd_i.sh_rd || cmd_i.rd_ord) begin
      ord_rd_q <= ord_mem[ord_raddr_c];
    end
    if (cmd_i.sh_wr) begin
      ord_mem[SLOT_W'(p_q)] <= ord_rd_q;
    end else if (cmd_i.place) begin
      ord_mem[SLOT_W'(lo_q)] <= SLOT_W'(cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_rd) begin
      len_rd_q <= len_mem[ord_rd_q];
    end
    if (cmd_i.place) begin
      len_mem[SLOT_W'(cnt_q)] <= klen_q;
    end
  end

  always_comb begin
    sts_o              = '0;
    sts_o.mode         = mode_q;
    sts_o.last         = last_q;
    sts_o.ovf          = povf_q;
    sts_o.enc_bad      = (enc_c.len == 3'd0);
    sts_o.lo_lt_hi     = (lo_q < hi_q);
    sts_o.cnt_full     = (cnt_q >= MaxCnt);
    sts_o.i_eq_m       = (i_q == m_c);
    sts_o.elen_eq_klen = (len_rd_q == klen_q);
    sts_o.elen_lt_klen = (len_rd_q < klen_q);
    sts_o.byte_eq      = (bytes_rd_q == kbyte_c);
    sts_o.byte_lt      = (bytes_rd_q < kbyte_c);
    sts_o.p_gt_lo      = (p_q > lo_q);
    sts_o.i_eq_klen    = (i_q == klen_q);
    sts_o.cp_final     = (cp_q == (blk_q ? BLK_PUNCT_LAST : BLK_LATIN_LAST));
    sts_o.idx_oob      = (32'(idx_q) >= 32'(cnt_q));
    sts_o.elen_zero    = (len_rd_q == '0);
    sts_o.rd_last      = rd_last_c;
    sts_o.out_free     = out_free_c;
  end

  assign res_valid_o   = res_vld_q;
  assign status_o      = res_st_q;
  assign entry_count_o = res_cnt_q;
  assign out_byte_o    = res_byte_q;
  assign out_valid_o   = res_bvld_q;
  assign out_length_o  = res_len_q;
  assign last_result_o = res_last_q;

`include "sorted_token_set_assert.svh"

  `STSET_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= MaxCnt, "entry count beyond capacity")
  `STSET_ASSERT_ALWAYS(a_search_window, lo_q <= hi_q && hi_q <= cnt_q, "search window broken")
  `STSET_ASSERT_ALWAYS(a_pend_bound, plen_q <= MaxLen, "pending token beyond maximum length")
  `STSET_ASSERT_IMPLY(a_emit_free, cmd_i.emit, out_free_c, "result emitted over a held result")

endmodule

/* src/sorted_token_set.sv */
// Sorted token set: keeps up to MAX_ENTRIES distinct byte strings of at most
// MAX_TOKEN_LEN bytes in unsigned lexicographic order, a prefix sorting first.
// One item is worked on at a time; the input is ready only while the block
// is idle, and a held result does not stop the next item from being taken.
// An add runs a binary search over the order table, comparing bytes per probe,
// then moves each entry that sorts after the new token down one slot (the
// order table is shifted one slot at a time through its single port) and
// copies the new token's bytes into its row. A duplicate finishes after
// the search. A block add repeats this for each codepoint, 128 or 112 in all.
// A read returns the entry's bytes one by one. Stored entries are kept
// in memory and need no clearing after reset.
module sorted_token_set import stset_pkg::*; #(
  parameter int unsigned MAX_ENTRIES   = 256,
  parameter int unsigned MAX_TOKEN_LEN = 32
) (
  input logic                clk_i,
  input logic                rst_ni,
  stset_in_if.sink           item_i,
  stset_out_if.source        result_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  stset_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stset_dp #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (item_i.mode),
    .data_byte_i    (item_i.data_byte),
    .has_byte_i     (item_i.has_byte),
    .last_i         (item_i.last),
    .codepoint_i    (item_i.codepoint),
    .block_select_i (item_i.block_select),
    .entry_index_i  (item_i.entry_index),
    .res_ready_i    (result_o.ready),
    .res_valid_o    (result_o.valid),
    .status_o       (result_o.status),
    .entry_count_o  (result_o.entry_count),
    .out_byte_o     (result_o.out_byte),
    .out_valid_o    (result_o.out_valid),
    .out_length_o   (result_o.out_length),
    .last_result_o  (result_o.last_result)
  );

endmodule
